// ===== sv/mpfr_pkg.sv =====
// Shared constants and types for the monochrome page frame store raster engine.
// Used by every module of the block but mpfr_ram; depends on nothing else.
package mpfr_pkg;

  localparam int COLUMNS     = 128;
  localparam int PAGES       = 8;
  localparam int HEIGHT      = PAGES * 8;
  localparam int STORE_DEPTH = COLUMNS * PAGES;

  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int PG_W   = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int ADDR_W = $clog2(STORE_DEPTH);

  // Command codes carried on the op field.
  localparam logic [2:0] OP_POINT   = 3'd0;
  localparam logic [2:0] OP_FILL    = 3'd1;
  localparam logic [2:0] OP_OUTLINE = 3'd2;
  localparam logic [2:0] OP_HLINE   = 3'd3;
  localparam logic [2:0] OP_VLINE   = 3'd4;
  localparam logic [2:0] OP_CLEAR   = 3'd5;
  localparam logic [2:0] OP_READ    = 3'd6;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_INIT_LAST,
    ST_IDLE,
    ST_SWEEP,
    ST_SWEEP_LAST,
    ST_RD_ISSUE,
    ST_RESULT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;
    logic walk;
    logic clear_all;
    logic rd_issue;
    logic out_load;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic walk_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/mono_page_framebuffer_raster.sv =====
// A read byte command shows the addressed store byte after a registered read;
// an unused op code shows a zero result without touching the store. Drawing and
// clear commands walk all 1024 store bytes through one read-modify-write pass
// and then show a zero result. The engine takes one command at a time.
// Reset (rst_n, synchronous, active low) starts a clearing sweep of the store,
// during which in_stall stays high.
//
// Top level of the monochrome page frame store raster engine. The store holds
// a 128 x 64 one-bit image as 128 columns of 8 page bytes; pixel (x, y) sits
// in page 7 - y/8 at bit 7 - y%8. The controller (mpfr_ctrl) sequences each
// command, and the datapath (mpfr_datapath) owns the command registers, the
// store walker, the per-byte pixel mask, the frame store RAM and the result
// register. Depends on mpfr_pkg, mpfr_ctrl, mpfr_datapath and mpfr_ram.
module mono_page_framebuffer_raster (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_op,
  input  logic [6:0] in_x_a,
  input  logic [5:0] in_y_a,
  input  logic [6:0] in_x_b,
  input  logic [5:0] in_y_b,
  input  logic [7:0] in_length,
  input  logic       in_color,
  input  logic [2:0] in_page,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data
);
  import mpfr_pkg::*;

  // The command bundle tells the datapath when to latch a transfer, when to
  // advance the walker and when to load the result register. The status
  // bundle reports the end of the walk and whether the result register can
  // take a new value this cycle.
  ctl_cmd_t   cmd;
  dp_status_t status;

  // The controller accepts a new command only when idle. A result still
  // waiting on out_stall does not block that; it only holds the controller
  // at the hand-off of the following result.
  mpfr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_op   (in_op),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  // Each walk cycle reads one store byte while the byte read in the previous cycle
  // is written back with its covered pixels set or cleared. Every byte is
  // visited once per command, so a read never meets its own pending write.
  mpfr_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_op        (in_op),
    .in_x_a       (in_x_a),
    .in_y_a       (in_y_a),
    .in_x_b       (in_x_b),
    .in_y_b       (in_y_b),
    .in_length    (in_length),
    .in_color     (in_color),
    .in_page      (in_page),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_read_data(out_read_data)
  );

endmodule

// ===== sv/mpfr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module mpfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/mpfr_datapath.sv =====
// Datapath: command registers, store walker, per-byte pixel mask, read-modify-write
// stage, frame store RAM and the result register. Depends on mpfr_pkg and mpfr_ram.
module mpfr_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  mpfr_pkg::ctl_cmd_t  cmd,
  output mpfr_pkg::dp_status_t status,
  input  logic [2:0]          in_op,
  input  logic [6:0]          in_x_a,
  input  logic [5:0]          in_y_a,
  input  logic [6:0]          in_x_b,
  input  logic [5:0]          in_y_b,
  input  logic [7:0]          in_length,
  input  logic                in_color,
  input  logic [2:0]          in_page,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_read_data
);
  import mpfr_pkg::*;

  // Command registers.
  logic [2:0] op_r;
  logic [6:0] xa_r;
  logic [5:0] ya_r;
  logic [6:0] xb_r;
  logic [5:0] yb_r;
  logic [7:0] len_r;
  logic       color_r;
  logic [2:0] page_r;

  // Walker.
  logic [COL_W-1:0]  walk_col_r, walk_col_nxt;
  logic [PG_W-1:0]   walk_pg_r, walk_pg_nxt;
  logic [ADDR_W-1:0] walk_addr_r, walk_addr_nxt;
  logic              walk_last;

  // Write stage.
  logic              wr_pend_r;
  logic [ADDR_W-1:0] wr_addr_r;
  logic [7:0]        wr_mask_r;
  logic              wr_set_r;
  logic              clr;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_read_data_r;

  // Mask logic.
  logic [8:0] cx, ybase, yy;
  logic [8:0] xa9, ya9, xb9, yb9, lx9, hx9, ly9, hy9;
  logic [7:0] lane_mask;

  // RAM side.
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] rd_byte_addr;
  logic              rd_in_range;
  logic [7:0]        rd_data;
  logic [7:0]        wr_data;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r    <= in_op;
      xa_r    <= in_x_a;
      ya_r    <= in_y_a;
      xb_r    <= in_x_b;
      yb_r    <= in_y_b;
      len_r   <= in_length;
      color_r <= in_color;
      page_r  <= in_page;
    end
  end

  assign walk_last = (walk_col_r == COL_W'(COLUMNS - 1)) && (walk_pg_r == PG_W'(PAGES - 1));

  always_comb begin
    walk_col_nxt  = walk_col_r;
    walk_pg_nxt   = walk_pg_r;
    walk_addr_nxt = walk_addr_r;
    if (cmd.walk) begin
      if (walk_last) begin
        walk_col_nxt  = '0;
        walk_pg_nxt   = '0;
        walk_addr_nxt = '0;
      end else begin
        walk_addr_nxt = walk_addr_r + ADDR_W'(1);
        if (walk_pg_r == PG_W'(PAGES - 1)) begin
          walk_pg_nxt  = '0;
          walk_col_nxt = walk_col_r + COL_W'(1);
        end else begin
          walk_pg_nxt = walk_pg_r + PG_W'(1);
        end
      end
    end
  end

  // Pixel coverage of the current byte, one lane per bit. Bit 7 is the top row
  // of the page, and pages count upward from the bottom of the screen.
  always_comb begin
    xa9   = 9'(xa_r);
    ya9   = 9'(ya_r);
    xb9   = 9'(xb_r);
    yb9   = 9'(yb_r);
    lx9   = (xa_r <= xb_r) ? xa9 : xb9;
    hx9   = (xa_r <= xb_r) ? xb9 : xa9;
    ly9   = (ya_r <= yb_r) ? ya9 : yb9;
    hy9   = (ya_r <= yb_r) ? yb9 : ya9;
    cx    = 9'(walk_col_r);
    ybase = (9'(PAGES - 1) - 9'(walk_pg_r)) << 3;
    yy    = ybase;
    lane_mask = '0;
    for (int b = 0; b < 8; b++) begin
      yy = ybase + 9'(7 - b);
      case (op_r)
        OP_POINT: lane_mask[b] = (cx == xa9) && (yy == ya9);
        OP_FILL: lane_mask[b] = (xa9 <= cx) && (cx <= xb9) && (ya9 <= yy) && (yy <= yb9);
        OP_OUTLINE: lane_mask[b] =
            (((cx == lx9) || (cx == hx9)) && (ly9 <= yy) && (yy <= hy9)) ||
            (((yy == ly9) || (yy == hy9)) && (lx9 <= cx) && (cx <= hx9));
        OP_HLINE: lane_mask[b] = (yy == ya9) && (8'(cx - xa9) < len_r);
        OP_VLINE: lane_mask[b] = (cx == xa9) && (8'(yy - ya9) < len_r);
        default: lane_mask[b] = 1'b0;
      endcase
    end
  end

  assign clr = cmd.clear_all || (op_r == OP_CLEAR);

  always_ff @(posedge clk) begin
    if (cmd.walk) begin
      wr_addr_r <= walk_addr_r;
      wr_mask_r <= clr ? 8'hFF : lane_mask;
      wr_set_r  <= !clr && color_r;
    end
  end

  assign wr_data = wr_set_r ? (rd_data | wr_mask_r) : (rd_data & ~wr_mask_r);

  assign rd_byte_addr = ADDR_W'(int'(xa_r) * PAGES + int'(page_r));
  assign rd_in_range  = (int'(xa_r) < COLUMNS) && (int'(page_r) < PAGES);
  assign rd_en        = cmd.walk || cmd.rd_issue;
  assign rd_addr      = cmd.walk ? walk_addr_r : rd_byte_addr;

  mpfr_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_pend_r),
    .wr_addr(wr_addr_r),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_read_data_r <= ((op_r == OP_READ) && rd_in_range) ? rd_data : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_col_r  <= '0;
      walk_pg_r   <= '0;
      walk_addr_r <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      walk_col_r  <= walk_col_nxt;
      walk_pg_r   <= walk_pg_nxt;
      walk_addr_r <= walk_addr_nxt;
      wr_pend_r   <= cmd.walk;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign status.walk_last = walk_last;
  assign status.out_free  = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_read_data    = out_read_data_r;

endmodule

// ===== sv/mpfr_ctrl.sv =====
// Controller state machine: reset clearing sweep, command sweeps, byte reads
// and result hand-off. Depends on mpfr_pkg.
module mpfr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [2:0]           in_op,
  output logic                 in_stall,
  input  mpfr_pkg::dp_status_t status,
  output mpfr_pkg::ctl_cmd_t   cmd
);
  import mpfr_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (status.walk_last) begin
          state_nxt = ST_INIT_LAST;
        end
      end
      ST_INIT_LAST: state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_READ) begin
            state_nxt = ST_RD_ISSUE;
          end else if (in_op <= OP_CLEAR) begin
            state_nxt = ST_SWEEP;
          end else begin
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_SWEEP: begin
        if (status.walk_last) begin
          state_nxt = ST_SWEEP_LAST;
        end
      end
      ST_SWEEP_LAST: state_nxt = ST_RESULT;
      ST_RD_ISSUE: state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_INIT: begin
        cmd.walk      = 1'b1;
        cmd.clear_all = 1'b1;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      ST_SWEEP: cmd.walk = 1'b1;
      ST_RD_ISSUE: cmd.rd_issue = 1'b1;
      ST_RESULT: cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/mpfr_checker.sv =====
// Port-level checks for the raster engine, attached to the top level by bind.
// Depends on mpfr_pkg and the top level mono_page_framebuffer_raster.
module mpfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [2:0] in_op,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_read_data
);
  import mpfr_pkg::*;

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_read_data)))
    else $error("stalled result changed");

  // The engine works one command at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("transfer taken while a command is in progress");

  // The store is being cleared right after reset, so no command is taken.
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("command taken during the reset clearing sweep");

  // A drawing or clear command still stalls the input early in its sweep.
  a_sweep_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_op <= OP_CLEAR)) |=> ##2 in_stall)
    else $error("sweep ended too early");

endmodule

bind mono_page_framebuffer_raster mpfr_checker u_mpfr_checker (.*);

// ===== bench/tb_mono_page_framebuffer_raster.sv =====
// Self-checking testbench for mono_page_framebuffer_raster, the 128 x 64 page frame store engine.
// Needs mpfr_pkg for the store geometry and the command codes; it reads no file.
// A directed table runs first, then random commands, checked against typed bytes or shadow store.
module tb_mono_page_framebuffer_raster;
  import mpfr_pkg::*;

  // The package names the seven real commands; code 7 is spare and must do nothing.
  localparam logic [2:0] OP_SPARE = 3'd7;

  // Length of the long receiver hold-off. It is far longer than one drawing
  // command, so the block finishes its work, keeps its result and stalls its input.
  localparam int HOLD_CYCLES = 3000;

  // Quiet time at the end. It is longer than a drawing command takes to show its result,
  // so this is enough to catch any stray transfer after the last expected one.
  localparam int DRAIN_CYCLES = 1100;

  typedef struct packed {
    logic [2:0] op;
    logic [6:0] x_a;
    logic [5:0] y_a;
    logic [6:0] x_b;
    logic [5:0] y_b;
    logic [7:0] length;
    logic       color;
    logic [2:0] page;
  } raster_cmd_t;

  // One row of the directed table. Where typed is set, typed_data is the byte
  // that must come back. Otherwise the shadow store decides.
  typedef struct packed {
    raster_cmd_t cmd;
    logic        typed;
    logic [7:0]  typed_data;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_op = '0;
  logic [6:0] in_x_a = '0;
  logic [5:0] in_y_a = '0;
  logic [6:0] in_x_b = '0;
  logic [5:0] in_y_b = '0;
  logic [7:0] in_length = '0;
  logic       in_color = 1'b0;
  logic [2:0] in_page = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_read_data;

  // Shadow of the frame store, in the same layout as the block:
  // index = column * PAGES + page.
  logic [7:0] shadow_page [STORE_DEPTH];

  // Bytes still owed by the block, oldest first. There is one per accepted command.
  logic [7:0] expected_bytes [$];
  logic [7:0] expected_head;

  stim_row_t  directed_rows [$];

  int unsigned send_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;

  // The main process asks for a long hold-off by bumping hold_requests.
  // The receiver process serves each request and counts the stretch itself.
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  // The x_a, y_a of the last random non-read command. Some random reads come back to it,
  // so that reads often find set bits and not just empty bytes.
  logic [6:0] last_x = '0;
  logic [5:0] last_y = '0;

  mono_page_framebuffer_raster i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_x_a        (in_x_a),
    .in_y_a        (in_y_a),
    .in_x_b        (in_x_b),
    .in_y_b        (in_y_b),
    .in_length     (in_length),
    .in_color      (in_color),
    .in_page       (in_page),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // This is a safety net only. The slowest correct run is about 475 commands,
  // many of them walking the whole store, plus the stalls, the hold-off and the
  // clearing sweep after reset. The limit below lies far beyond that.
  initial begin
    #40000000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at result %0d: %s", results_seen, what);
    mismatch_count++;
  endtask

  // Set or clear one pixel. Pixels off the screen are dropped.
  function automatic void paint_pixel(int unsigned x, int unsigned y, logic color);
    int unsigned idx;
    logic [7:0]  mask;
    if (x >= COLUMNS || y >= HEIGHT) return;
    idx  = x * PAGES + (PAGES - 1 - y / 8);
    mask = 8'h80 >> (y % 8);
    if (color) shadow_page[idx] = shadow_page[idx] | mask;
    else shadow_page[idx] = shadow_page[idx] & ~mask;
  endfunction

  // Line coordinates wrap at 256 first and are clipped after that, so a long
  // line that runs off the right or bottom edge comes back in at column or row 0.
  function automatic void paint_hline(int unsigned x, int unsigned y, int unsigned len,
                                      logic color);
    int unsigned i;
    for (i = 0; i < len; i++) paint_pixel((x + i) % 256, y, color);
  endfunction

  function automatic void paint_vline(int unsigned x, int unsigned y, int unsigned len,
                                      logic color);
    int unsigned i;
    for (i = 0; i < len; i++) paint_pixel(x, (y + i) % 256, color);
  endfunction

  // Apply one command to the shadow store and return the byte the block must send back.
  function automatic logic [7:0] apply_command(raster_cmd_t c);
    int unsigned xa, ya, xb, yb, t, x, y;
    logic [7:0]  data;
    xa   = c.x_a;
    ya   = c.y_a;
    xb   = c.x_b;
    yb   = c.y_b;
    data = 8'h00;
    case (c.op)
      OP_POINT: paint_pixel(xa, ya, c.color);
      OP_FILL: begin
        // A fill with a reversed corner draws nothing. The empty loops handle it.
        for (x = xa; x <= xb; x++)
          for (y = ya; y <= yb; y++) paint_pixel(x, y, c.color);
      end
      OP_OUTLINE: begin
        // An outline sorts its corners first, so a reversed outline still draws.
        if (xa > xb) begin
          t  = xa;
          xa = xb;
          xb = t;
        end
        if (ya > yb) begin
          t  = ya;
          ya = yb;
          yb = t;
        end
        paint_vline(xa, ya, yb - ya + 1, c.color);
        paint_vline(xb, ya, yb - ya + 1, c.color);
        paint_hline(xa, ya, xb - xa + 1, c.color);
        paint_hline(xa, yb, xb - xa + 1, c.color);
      end
      OP_HLINE: paint_hline(xa, ya, c.length, c.color);
      OP_VLINE: paint_vline(xa, ya, c.length, c.color);
      OP_CLEAR: foreach (shadow_page[i]) shadow_page[i] = 8'h00;
      OP_READ: begin
        if (xa < COLUMNS && c.page < PAGES) data = shadow_page[xa * PAGES + c.page];
      end
      default: ;
    endcase
    return data;
  endfunction

  function automatic stim_row_t table_row(logic [2:0] op, int unsigned xa, int unsigned ya,
                                          int unsigned xb, int unsigned yb, int unsigned len,
                                          int unsigned color, int unsigned page,
                                          int unsigned typed, int unsigned data);
    stim_row_t r;
    r.cmd.op     = op;
    r.cmd.x_a    = 7'(xa);
    r.cmd.y_a    = 6'(ya);
    r.cmd.x_b    = 7'(xb);
    r.cmd.y_b    = 6'(yb);
    r.cmd.length = 8'(len);
    r.cmd.color  = 1'(color);
    r.cmd.page   = 3'(page);
    r.typed      = 1'(typed);
    r.typed_data = 8'(data);
    return r;
  endfunction

  // Random command mix. Reads are cheap and most other commands walk the whole
  // store, so reads are common. This keeps the run short and still looks at the
  // image often.
  function automatic raster_cmd_t random_command();
    raster_cmd_t c;
    int unsigned pick;
    logic [6:0]  tx;
    logic [5:0]  ty;
    pick     = $urandom_range(99);
    c.x_a    = 7'($urandom_range(127));
    c.y_a    = 6'($urandom_range(63));
    c.x_b    = 7'($urandom_range(127));
    c.y_b    = 6'($urandom_range(63));
    c.color  = 1'($urandom_range(1));
    c.page   = 3'($urandom_range(7));
    c.length = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(40));
    if (pick < 45) begin
      c.op = OP_READ;
      if ($urandom_range(1) == 1) begin
        c.x_a  = last_x;
        c.page = ~last_y[5:3];
      end
    end else begin
      if (pick < 60) c.op = OP_POINT;
      else if (pick < 70) c.op = OP_FILL;
      else if (pick < 78) c.op = OP_OUTLINE;
      else if (pick < 86) c.op = OP_HLINE;
      else if (pick < 94) c.op = OP_VLINE;
      else if (pick < 97) c.op = OP_SPARE;
      else c.op = OP_CLEAR;
      // Three fills out of four get their corners in order, so that most fills draw.
      if (c.op == OP_FILL && $urandom_range(3) != 0) begin
        if (c.x_a > c.x_b) begin
          tx    = c.x_a;
          c.x_a = c.x_b;
          c.x_b = tx;
        end
        if (c.y_a > c.y_b) begin
          ty    = c.y_a;
          c.y_a = c.y_b;
          c.y_b = ty;
        end
      end
      last_x = c.x_a;
      last_y = c.y_a;
    end
    return c;
  endfunction

  // Offer one command and wait for its transfer. An idle gap comes first and may
  // be empty. After the transfer, in_valid stays high. The next call either lowers
  // it for a gap or puts the next command straight onto the port, so in_valid
  // gets at most one update per edge.
  task automatic send_command(input raster_cmd_t c, input logic typed,
                              input logic [7:0] typed_data);
    logic [7:0] predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_op     <= c.op;
    in_x_a    <= c.x_a;
    in_y_a    <= c.y_a;
    in_x_b    <= c.x_b;
    in_y_b    <= c.y_b;
    in_length <= c.length;
    in_color  <= c.color;
    in_page   <= c.page;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // The transfer happened at this edge. Update the shadow store now, even for
    // rows whose result is typed in, so that the rows after them are predicted right.
    predicted = apply_command(c);
    expected_bytes.push_back(typed ? typed_data : predicted);
  endtask

  // Receiver. Results are sampled at the rising edge, before anything driven at
  // that edge takes effect. out_stall is random at the current idle rate, or
  // held high through a requested hold-off.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("read_data %02h arrived with nothing pending", out_read_data));
      end else begin
        expected_head = expected_bytes.pop_front();
        if (out_read_data !== expected_head)
          report_mismatch($sformatf("read_data %02h, want %02h", out_read_data, expected_head));
      end
    end
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  initial begin
    int unsigned phase;
    foreach (shadow_page[i]) shadow_page[i] = 8'h00;

    // Directed table. Read rows whose byte is obvious from the rows above them,
    // and every drawing row (they always return zero), are typed in. The reads after
    // the outline and the wrapping lines are left to the shadow store.
    directed_rows.push_back(table_row(OP_READ,      0,  0,   0,  0,   0, 0, 0, 1, 8'h00));
    directed_rows.push_back(table_row(OP_READ,    127, 63, 127, 63, 255, 1, 7, 1, 8'h00));
    directed_rows.push_back(table_row(OP_POINT,     0,  0,   0,  0,   0, 1, 0, 1, 8'h00));
    directed_rows.push_back(table_row(OP_READ,      0,  0,   0,  0,   0, 0, 7, 1, 8'h80));
    directed_rows.push_back(table_row(OP_POINT,   127, 63, 127, 63, 255, 1, 7, 1, 8'h00));
    directed_rows.push_back(table_row(OP_READ,    127,  0,   0,  0,   0, 0, 0, 1, 8'h01));
    directed_rows.push_back(table_row(OP_POINT,   127, 63,   0,  0,   0, 0, 0, 1, 8'h00));
    directed_rows.push_back(table_row(OP_READ,    127,  0,   0,  0,   0, 0, 0, 1, 8'h00));
    directed_rows.push_back(table_row(OP_FILL,      0,  0, 127, 63,   0, 1, 0, 1, 8'h00));
    directed_rows.push_back(table_row(OP_READ,     64,  0,   0,  0,   0, 0, 3, 1, 8'hFF));
    // A fill with a reversed column and then one with a reversed row: both must
    // leave the solid image alone.
    directed_rows.push_back(table_row(OP_FILL,     10,  0,   5,  5,   0, 0, 0, 1, 8'h00));
    directed_rows.push_back(table_row(OP_READ,      7,  0,   0,  0,   0, 0, 7, 1, 8'hFF));
    directed_rows.push_back(table_row(OP_FILL,      0, 10,   5,  2,   0, 0, 0, 1, 8'h00));
    directed_rows.push_back(table_row(OP_READ,      3,  0,   0,  0,   0, 0, 6, 1, 8'hFF));
    directed_rows.push_back(table_row(OP_CLEAR,   127, 63, 127, 63, 255, 1, 7, 1, 8'h00));
    directed_rows.push_back(table_row(OP_READ,     64,  0,   0,  0,   0, 0, 3, 1, 8'h00));
    // An outline given with both corners reversed.
    directed_rows.push_back(table_row(OP_OUTLINE, 100, 50,  20,  3,   0, 1, 0, 1, 8'h00));
    directed_rows.push_back(table_row(OP_READ,     20,  0,   0,  0,   0, 0, 7, 0, 8'h00));
    directed_rows.push_back(table_row(OP_READ,     60,  0,   0,  0,   0, 0, 7, 0, 8'h00));
    // Lines of full length that wrap past the edge, then lines of length zero.
    directed_rows.push_back(table_row(OP_HLINE,   120,  8,   0,  0, 255, 1, 0, 1, 8'h00));
    directed_rows.push_back(table_row(OP_READ,      5,  0,   0,  0,   0, 0, 6, 0, 8'h00));
    directed_rows.push_back(table_row(OP_VLINE,     3, 60,   0,  0, 255, 1, 0, 1, 8'h00));
    directed_rows.push_back(table_row(OP_HLINE,     0, 20,   0,  0,   0, 1, 0, 1, 8'h00));
    directed_rows.push_back(table_row(OP_VLINE,    40,  0,   0,  0,   0, 1, 0, 1, 8'h00));
    directed_rows.push_back(table_row(OP_SPARE,   127, 63, 127, 63, 255, 1, 7, 1, 8'h00));
    directed_rows.push_back(table_row(OP_READ,      3,  0,   0,  0,   0, 0, 0, 0, 8'h00));

    // Reset is held low once, at the start. The block then runs its own clearing
    // sweep with in_stall high, and the first transfer simply waits for it.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Phase 0 has a lazy sender and a very busy receiver. The directed table runs under it.
    send_idle_pct = 37;
    rx_idle_pct   = 86;
    foreach (directed_rows[i])
      send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].typed_data);

    for (phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        // The rates swap. First the sender stops and waits until every
        // outstanding result has been transferred.
        send_idle_pct = 86;
        rx_idle_pct   = 37;
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_bytes.size() != 0);
      end
      if (phase == 2) begin
        // No idling on either side, apart from one long receiver hold-off. The
        // sender keeps offering commands through it, so the block backs up.
        send_idle_pct = 0;
        rx_idle_pct   = 0;
        hold_requests++;
      end
      repeat (150) send_command(random_command(), 1'b0, 8'h00);
    end

    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
sv/mpfr_pkg.sv
sv/mpfr_ram.sv
sv/mpfr_datapath.sv
sv/mpfr_ctrl.sv
sv/mono_page_framebuffer_raster.sv
sv/mpfr_checker.sv
bench/tb_mono_page_framebuffer_raster.sv
